FILE: rtl/core/lmbr_pkg.sv
// shared types, constants and helpers for the led matrix blink refresh unit
`timescale 1ns / 1ps

package lmbr_pkg;

    localparam int PIXELS     = 64;
    localparam int IDX_W      = $clog2(PIXELS);
    localparam int PIX_ADDR_W = 6;
    localparam int ADDR_W     = 7;
    localparam int REQ_W      = 3;
    localparam int MASK_W     = 64;
    localparam int PERIOD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [PIX_ADDR_W-1:0] PIX_LAST = 6'd63;
    localparam logic [2:0]            COL_MASK = 3'd7;

    localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ON    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_OFF   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INV   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FAST  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SLOW  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd6;
    localparam logic [REQ_W-1:0] REQ_NONE  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATED     = 2'd2;

    typedef logic [PIXELS-1:0]   pix_t;
    typedef logic [PERIOD_W-1:0] period_t;

    typedef struct packed {
        logic [ADDR_W-1:0] led_addr;
        logic              led_state;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic flush;
        cmd_t cmd;
    } emit_ctrl_t;

    typedef struct packed {
        logic push_block;
        logic flush_done;
    } emit_stat_t;

    // phase counter step, wraps at the period (a zero period acts as one)
    function automatic period_t advance_phase(input period_t phase, input period_t period);
        logic [PERIOD_W:0] nxt;
        begin
            nxt = {1'b0, phase} + {{PERIOD_W{1'b0}}, 1'b1};
            if (nxt >= {1'b0, period})
            begin
                advance_phase = '0;
            end
            else
            begin
                advance_phase = nxt[PERIOD_W-1:0];
            end
        end
    endfunction

    // pixel index to driver address, optionally mirrored for a rotated board
    function automatic logic [ADDR_W-1:0] led_address(input logic [PIX_ADDR_W-1:0] p,
                                                     input logic rotated);
        logic [PIX_ADDR_W-1:0] q;
        begin
            q = rotated ? (PIX_LAST - p) : p;
            led_address = {q[5:3], 1'b0, q[2:0] & COL_MASK};
        end
    endfunction

endpackage

FILE: rtl/core/lmbr_req_if.sv
// request channel: request type and pixel mask
`timescale 1ns / 1ps

interface lmbr_req_if;
    logic                          valid;
    logic                          ready;
    logic [lmbr_pkg::REQ_W-1:0]    req_type;
    logic [lmbr_pkg::MASK_W-1:0]   mask_bits;

    modport source (output valid, output req_type, output mask_bits, input ready);
    modport sink   (input valid, input req_type, input mask_bits, output ready);
endinterface

FILE: rtl/core/lmbr_cmd_if.sv
// led command channel: driver address, new state and end-of-tick flag
`timescale 1ns / 1ps

interface lmbr_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [lmbr_pkg::ADDR_W-1:0]   led_addr;
    logic                          led_state;
    logic                          last;

    modport source (output valid, output led_addr, output led_state, output last, input ready);
    modport sink   (input valid, input led_addr, input led_state, input last, output ready);
endinterface

FILE: rtl/core/lmbr_emit.sv
// command output stage: holds one command back so the final one can carry last
`timescale 1ns / 1ps

module lmbr_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lmbr_pkg::emit_ctrl_t  ctrl,
    output lmbr_pkg::emit_stat_t  stat,
    lmbr_cmd_if.source            cmd
);

    logic               pend_valid_reg, pend_valid_next;
    lmbr_pkg::cmd_t     pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    lmbr_pkg::cmd_t     out_reg, out_next;
    logic               free;

    assign free            = !out_valid_reg || cmd.ready;
    assign stat.push_block = ctrl.push && pend_valid_reg && !free;
    assign stat.flush_done = !pend_valid_reg || free;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !cmd.ready;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (ctrl.push && !stat.push_block)
        begin
            // a newer toggle exists, so the held command is not the last one
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.last  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = ctrl.cmd;
        end
        else if (ctrl.flush && pend_valid_reg && free)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign cmd.valid     = out_valid_reg;
    assign cmd.led_addr  = out_reg.led_addr;
    assign cmd.led_state = out_reg.led_state;
    assign cmd.last      = out_reg.last;

endmodule

FILE: rtl/core/led_matrix_blink_refresh_unit.sv
// top level: bitmap and blink masks in rotating shift registers, tick scan
`timescale 1ns / 1ps

//  channel   direction  handshake            payload
//  req       in         req.valid/ready      req_type, mask_bits
//  cmd       out        cmd.valid/ready      led_addr, led_state, last
//  cfg       in         cfg_we (no wait)     cfg_idx, cfg_data
//
//  every request except the unused code is accepted in the idle state, then the pixel and mask
//  shift registers rotate one bit a cycle, while the scan does not stall, through all 64 pixels;
//  a tick then adds a flush state to release the final command
//  the unused request code is taken without a scan and does nothing
//  the scan stalls while a toggle finds the output stage full, and the final release waits
//  the same way
//  reset blanks the bitmaps and masks, clears both phases and loads the register defaults

module led_matrix_blink_refresh_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    lmbr_req_if.sink                           req,
    lmbr_cmd_if.source                         cmd,
    input  logic                               cfg_we,
    input  logic [lmbr_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [lmbr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [lmbr_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [lmbr_pkg::REQ_W-1:0]      op_reg, op_next;
    logic                            fz_reg, fz_next;
    logic                            sz_reg, sz_next;

    lmbr_pkg::pix_t                  target_reg, target_next;
    lmbr_pkg::pix_t                  fast_reg, fast_next;
    lmbr_pkg::pix_t                  slow_reg, slow_next;
    lmbr_pkg::pix_t                  shown_reg, shown_next;
    lmbr_pkg::pix_t                  mask_reg, mask_next;

    lmbr_pkg::period_t               fast_period_reg, slow_period_reg;
    logic                            rotated_reg;
    lmbr_pkg::period_t               fast_phase_reg, fast_phase_next;
    lmbr_pkg::period_t               slow_phase_reg, slow_phase_next;

    logic                            bt, bf, bs, bsh, bm;
    logic                            nt, nf, ns, nsh, toggle;
    logic                            step, at_end;

    lmbr_pkg::emit_ctrl_t            ectrl;
    lmbr_pkg::emit_stat_t            estat;

    assign bt  = target_reg[0];
    assign bf  = fast_reg[0];
    assign bs  = slow_reg[0];
    assign bsh = shown_reg[0];
    assign bm  = mask_reg[0];

    // per-pixel update of the bit leaving the bottom of each register
    always_comb
    begin
        nt     = bt;
        nf     = bf;
        ns     = bs;
        nsh    = bsh;
        toggle = 1'b0;
        case (op_reg)
            lmbr_pkg::REQ_SET:
            begin
                nt = bm;
                nf = 1'b0;
                ns = 1'b0;
            end
            lmbr_pkg::REQ_ON:
            begin
                nt = bt | bm;
                nf = bf & ~bm;
                ns = bs & ~bm;
            end
            lmbr_pkg::REQ_OFF:
            begin
                nt = bt & ~bm;
                nf = bf & ~bm;
                ns = bs & ~bm;
            end
            lmbr_pkg::REQ_INV:
            begin
                nt = bt ^ bm;
                nf = bf & ~bm;
                ns = bs & ~bm;
            end
            lmbr_pkg::REQ_FAST:
            begin
                nt = bt & ~bm;
                nf = bf | bm;
                ns = bs & ~bm;
            end
            lmbr_pkg::REQ_SLOW:
            begin
                nt = bt & ~bm;
                nf = bf & ~bm;
                ns = bs | bm;
            end
            lmbr_pkg::REQ_TICK:
            begin
                toggle = ((bsh ^ bt) & ~(bf | bs)) | (fz_reg & bf) | (sz_reg & bs);
                nsh    = bsh ^ toggle;
            end
            default:
            begin
                toggle = 1'b0;
            end
        endcase
    end

    assign ectrl.push           = (state_reg == ST_SCAN) && toggle;
    assign ectrl.flush          = (state_reg == ST_FLUSH);
    assign ectrl.cmd.led_addr   = lmbr_pkg::led_address(lmbr_pkg::PIX_ADDR_W'(idx_reg),
                                                        rotated_reg);
    assign ectrl.cmd.led_state  = ~bsh;
    assign ectrl.cmd.last       = 1'b0;

    assign step   = (state_reg == ST_SCAN) && !estat.push_block;
    assign at_end = (idx_reg == lmbr_pkg::IDX_W'(lmbr_pkg::PIXELS - 1));

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        fz_next         = fz_reg;
        sz_next         = sz_reg;
        target_next     = target_reg;
        fast_next       = fast_reg;
        slow_next       = slow_reg;
        shown_next      = shown_reg;
        mask_next       = mask_reg;
        fast_phase_next = fast_phase_reg;
        slow_phase_next = slow_phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mask_next = req.mask_bits[lmbr_pkg::PIXELS-1:0];
                    op_next   = req.req_type;
                    fz_next   = (fast_phase_reg == '0);
                    sz_next   = (slow_phase_reg == '0);
                    idx_next  = '0;
                    if (req.req_type != lmbr_pkg::REQ_NONE)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    // rotate: after a full pass every register is back in place
                    target_next = {nt, target_reg[lmbr_pkg::PIXELS-1:1]};
                    fast_next   = {nf, fast_reg[lmbr_pkg::PIXELS-1:1]};
                    slow_next   = {ns, slow_reg[lmbr_pkg::PIXELS-1:1]};
                    shown_next  = {nsh, shown_reg[lmbr_pkg::PIXELS-1:1]};
                    mask_next   = {bm, mask_reg[lmbr_pkg::PIXELS-1:1]};
                    idx_next    = idx_reg + lmbr_pkg::IDX_W'(1);
                    if (at_end)
                    begin
                        if (op_reg == lmbr_pkg::REQ_TICK)
                        begin
                            fast_phase_next = lmbr_pkg::advance_phase(fast_phase_reg,
                                                                      fast_period_reg);
                            slow_phase_next = lmbr_pkg::advance_phase(slow_phase_reg,
                                                                      slow_period_reg);
                            state_next      = ST_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (estat.flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            op_reg          <= lmbr_pkg::REQ_NONE;
            fz_reg          <= 1'b0;
            sz_reg          <= 1'b0;
            target_reg      <= '0;
            fast_reg        <= '0;
            slow_reg        <= '0;
            shown_reg       <= '0;
            fast_phase_reg  <= '0;
            slow_phase_reg  <= '0;
            fast_period_reg <= 8'd5;
            slow_period_reg <= 8'd20;
            rotated_reg     <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            op_reg         <= op_next;
            fz_reg         <= fz_next;
            sz_reg         <= sz_next;
            target_reg     <= target_next;
            fast_reg       <= fast_next;
            slow_reg       <= slow_next;
            shown_reg      <= shown_next;
            fast_phase_reg <= fast_phase_next;
            slow_phase_reg <= slow_phase_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    lmbr_pkg::CFG_FAST_PERIOD: fast_period_reg <= cfg_data;
                    lmbr_pkg::CFG_SLOW_PERIOD: slow_period_reg <= cfg_data;
                    lmbr_pkg::CFG_ROTATED:     rotated_reg     <= cfg_data[0];
                    default:                   rotated_reg     <= rotated_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
    end

    lmbr_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ectrl),
        .stat  (estat),
        .cmd   (cmd)
    );

endmodule

FILE: bench/lmbr_refresh_checker.sv
// checker for the led matrix refresh unit: mirrors frame state and checks led commands
`timescale 1ns / 1ps

module lmbr_refresh_checker
    import lmbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    lmbr_req_if                   req,
    lmbr_cmd_if                   cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    pix_t    target_pix;
    pix_t    fast_pix;
    pix_t    slow_pix;
    pix_t    shown_pix;
    period_t fast_count;
    period_t slow_count;
    period_t fast_len;
    period_t slow_len;
    logic    mirror;

    cmd_t    pending_led_cmds[$];

    function automatic period_t next_phase(input period_t ph, input period_t len);
        logic [PERIOD_W:0] sum;
        begin
            sum = {1'b0, ph} + 1'b1;
            next_phase = (sum >= {1'b0, len}) ? '0 : sum[PERIOD_W-1:0];
        end
    endfunction

    function automatic logic [ADDR_W-1:0] driver_addr(input int unsigned p, input logic rot);
        logic [5:0] q;
        begin
            q = rot ? ~p[5:0] : p[5:0];
            driver_addr = {q[5:3], 1'b0, q[2:0]};
        end
    endfunction

    // edit the bitmap and blink masks, or work out the toggles of a tick
    function automatic void apply_frame_request(input logic [REQ_W-1:0] kind, input pix_t m);
        pix_t flips;
        cmd_t c;
        begin
            case (kind)
                REQ_SET:
                begin
                    target_pix = m;
                    fast_pix   = '0;
                    slow_pix   = '0;
                end
                REQ_ON:
                begin
                    target_pix |= m;
                    fast_pix   &= ~m;
                    slow_pix   &= ~m;
                end
                REQ_OFF:
                begin
                    target_pix &= ~m;
                    fast_pix   &= ~m;
                    slow_pix   &= ~m;
                end
                REQ_INV:
                begin
                    target_pix ^= m;
                    fast_pix   &= ~m;
                    slow_pix   &= ~m;
                end
                REQ_FAST:
                begin
                    target_pix &= ~m;
                    fast_pix   |= m;
                    slow_pix   &= ~m;
                end
                REQ_SLOW:
                begin
                    target_pix &= ~m;
                    slow_pix   |= m;
                    fast_pix   &= ~m;
                end
                REQ_TICK:
                begin
                    flips = (shown_pix ^ target_pix) & ~(fast_pix | slow_pix);
                    if (fast_count == '0)
                    begin
                        flips |= fast_pix;
                    end
                    if (slow_count == '0)
                    begin
                        flips |= slow_pix;
                    end
                    for (int unsigned p = 0; p < PIXELS; p++)
                    begin
                        if (flips[p])
                        begin
                            c.led_addr  = driver_addr(p, mirror);
                            c.led_state = ~shown_pix[p];
                            // final command when no higher pixel toggles
                            c.last      = ((flips >> (p + 1)) == '0);
                            pending_led_cmds.push_back(c);
                        end
                    end
                    shown_pix ^= flips;
                    fast_count = next_phase(fast_count, fast_len);
                    slow_count = next_phase(slow_count, slow_len);
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t want;
        if (!rst_n)
        begin
            target_pix = '0;
            fast_pix   = '0;
            slow_pix   = '0;
            shown_pix  = '0;
            fast_count = '0;
            slow_count = '0;
            fast_len   = 8'd5;
            slow_len   = 8'd20;
            mirror     = 1'b1;
            pending_led_cmds.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_FAST_PERIOD: fast_len = cfg_data;
                    CFG_SLOW_PERIOD: slow_len = cfg_data;
                    CFG_ROTATED:     mirror   = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.valid && cmd.ready)
            begin
                if (pending_led_cmds.size() == 0)
                begin
                    $error("led command with none expected: led_addr %0d led_state %0d last %0d",
                           cmd.led_addr, cmd.led_state, cmd.last);
                    fail_count++;
                end
                else
                begin
                    want = pending_led_cmds.pop_front();
                    if (cmd.led_addr !== want.led_addr)
                    begin
                        $error("led_addr expected %0d actual %0d", want.led_addr, cmd.led_addr);
                        fail_count++;
                    end
                    if (cmd.led_state !== want.led_state)
                    begin
                        $error("led_state expected %0d actual %0d", want.led_state,
                               cmd.led_state);
                        fail_count++;
                    end
                    if (cmd.last !== want.last)
                    begin
                        $error("last expected %0d actual %0d", want.last, cmd.last);
                        fail_count++;
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                apply_frame_request(req.req_type, req.mask_bits);
            end

            outstanding = pending_led_cmds.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// top of the refresh unit bench: clock, reset, request and register stimulus, verdict
`timescale 1ns / 1ps

module testbench;
    import lmbr_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    cycle_count = 0;
    int                    check_fails;
    int                    cmds_waiting;

    lmbr_req_if req_ch ();
    lmbr_cmd_if cmd_ch ();

    led_matrix_blink_refresh_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .cmd      (cmd_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    lmbr_refresh_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .cmd         (cmd_ch),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .fail_count  (check_fails),
        .outstanding (cmds_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // led command sink with random back-pressure
    initial
    begin
        cmd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cmd_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // offer one request, with random idle cycles ahead of it, and wait for the transaction
    task automatic send_frame_req(input logic [REQ_W-1:0] kind, input pix_t m);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.mask_bits <= m;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold off until every led command is out and the scan has finished
    task automatic wait_frame_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (cmds_waiting != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic pix_t pick_mask();
        pix_t a;
        pix_t b;
        pix_t c;
        begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
            c = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0:       pick_mask = '1;
                1:       pick_mask = '0;
                2:       pick_mask = a & b & c;
                3:       pick_mask = pix_t'(1) << $urandom_range(0, PIXELS - 1);
                4:       pick_mask = a | b;
                default: pick_mask = a;
            endcase
        end
    endfunction

    task automatic run_random(input int count);
        int                 done;
        int                 roll;
        logic [REQ_W-1:0]   kind;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                kind = REQ_NONE;
            end
            else if (roll < 42)
            begin
                kind = REQ_TICK;
            end
            else
            begin
                kind = REQ_W'($urandom_range(REQ_SET, REQ_SLOW));
            end
            send_frame_req(kind, pick_mask());
            if (kind != REQ_NONE)
            begin
                done++;
            end
            if ($urandom_range(0, 99) < 2)
            begin
                wait_frame_idle();
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_FAST_PERIOD;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_NONE;
        req_ch.mask_bits <= '0;
        send_idle_pct     = 30;
        recv_idle_pct     = 69;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset register values
        send_frame_req(REQ_TICK, '0);
        send_frame_req(REQ_SET, '1);
        send_frame_req(REQ_TICK, '1);
        send_frame_req(REQ_NONE, {$urandom, $urandom});
        send_frame_req(REQ_TICK, {$urandom, $urandom});
        send_frame_req(REQ_OFF, 64'hAAAA_AAAA_AAAA_AAAA);
        send_frame_req(REQ_INV, 64'h0F0F_0F0F_0F0F_0F0F);
        send_frame_req(REQ_ON, 64'h0000_0000_0000_0001);
        send_frame_req(REQ_TICK, {$urandom, $urandom});
        send_frame_req(REQ_FAST, 64'h8000_0000_0000_0001);
        send_frame_req(REQ_SLOW, 64'h00FF_0000_0000_FF00);
        repeat (6) send_frame_req(REQ_TICK, {$urandom, $urandom});
        send_frame_req(REQ_SET, '0);
        send_frame_req(REQ_TICK, '1);
        wait_frame_idle();

        // long periods, direct mapping
        write_reg(CFG_FAST_PERIOD, 8'd255);
        write_reg(CFG_SLOW_PERIOD, 8'd255);
        write_reg(CFG_ROTATED, 8'd0);
        run_random(160);
        wait_frame_idle();

        // zero and short periods, lowered below the running phase counters
        send_idle_pct = 69;
        recv_idle_pct = 30;
        write_reg(CFG_FAST_PERIOD, 8'd0);
        write_reg(CFG_SLOW_PERIOD, 8'd3);
        write_reg(CFG_ROTATED, 8'd1);
        run_random(160);
        wait_frame_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_FAST_PERIOD, 8'd1);
        write_reg(CFG_SLOW_PERIOD, CFG_DATA_W'($urandom_range(2, 40)));
        write_reg(CFG_ROTATED, CFG_DATA_W'($urandom_range(0, 1)));
        run_random(160);
        wait_frame_idle();

        if (check_fails == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/lmbr_pkg.sv
rtl/core/lmbr_req_if.sv
rtl/core/lmbr_cmd_if.sv
rtl/core/lmbr_emit.sv
rtl/core/led_matrix_blink_refresh_unit.sv
bench/lmbr_refresh_checker.sv
bench/testbench.sv
